/* hw/rtl/r2h_pkg.sv */
// r2h_pkg: shared types and constants for the RGB to HSV converter.
// No dependencies; used by all r2h_* modules and the top level.
`default_nettype none

package r2h_pkg;

  localparam int CH_W    = 8;   // color channel width
  localparam int HUE_W   = 13;  // hue output width, sixteenths of a degree
  localparam int QBITS   = 10;  // quotient bits resolved by the divider chain
  localparam int REM_W   = 18;  // partial remainder width
  localparam int HSUM_W  = 14;  // signed hue sum before wrap

  localparam logic [HSUM_W-1:0] HUE_SECTOR = 14'd960;
  localparam logic [HSUM_W-1:0] HUE_FULL   = 14'd5760;

  // which channel is the largest; decides the hue offset
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // word carried along the divider chain
  typedef struct packed {
    logic [CH_W-1:0]  mx;       // largest channel, also the saturation divisor
    logic [CH_W-1:0]  delta;    // max - min, the hue divisor
    logic             grey;     // all channels equal
    logic             neg;      // hue difference was negative
    sector_t          sector;
    logic [REM_W-1:0] sat_rem;
    logic [REM_W-1:0] hue_rem;
    logic [QBITS-1:0] sat_q;
    logic [QBITS-1:0] hue_q;
  } stage_t;

endpackage

`default_nettype wire

/* hw/rtl/r2h_if.sv */
// r2h_if: valid/ready channel interfaces for the RGB to HSV converter.
// Depends on r2h_pkg for field widths.
`default_nettype none

interface r2h_rgb_if;
  logic                      valid;
  logic                      ready;
  logic [r2h_pkg::CH_W-1:0]  red;
  logic [r2h_pkg::CH_W-1:0]  green;
  logic [r2h_pkg::CH_W-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface r2h_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [r2h_pkg::HUE_W-1:0]  hue;
  logic [r2h_pkg::CH_W-1:0]   saturation;
  logic [r2h_pkg::CH_W-1:0]   brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

`default_nettype wire

/* hw/rtl/r2h_front.sv */
// r2h_front: input stage; finds max/min, sector and both dividends.
// Depends on r2h_pkg and r2h_rgb_if.
`default_nettype none

module r2h_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  r2h_rgb_if.sink             pix,
  output logic                valid,
  output r2h_pkg::stage_t     stage
);

  logic [7:0]            mx, mn, delta;
  logic signed [8:0]     diff;
  logic [7:0]            mag;
  r2h_pkg::sector_t      sector;
  r2h_pkg::stage_t       stage_next;

  assign pix.ready = en;

  always_comb begin
    mx = pix.red;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue > mx) mx = pix.blue;
    mn = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    delta = mx - mn;

    // tie order: red, then green, then blue
    if (pix.red == mx) begin
      sector = r2h_pkg::SEC_RED;
      diff   = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
    end else if (pix.green == mx) begin
      sector = r2h_pkg::SEC_GREEN;
      diff   = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
    end else begin
      sector = r2h_pkg::SEC_BLUE;
      diff   = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
    end
    mag = diff[8] ? 8'(-diff) : diff[7:0];

    stage_next.mx      = mx;
    stage_next.delta   = delta;
    stage_next.grey    = (delta == 8'd0);
    stage_next.neg     = diff[8];
    stage_next.sector  = sector;
    // delta*255 and mag*960 as shift-and-subtract
    stage_next.sat_rem = ({10'd0, delta} << 8) - {10'd0, delta};
    stage_next.hue_rem = ({10'd0, mag} << 10) - ({10'd0, mag} << 6);
    stage_next.sat_q   = '0;
    stage_next.hue_q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= pix.valid;
    end
    if (en) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/r2h_cell.sv */
// r2h_cell: one restoring-division step for both saturation and hue.
// Depends on r2h_pkg. Resolves quotient bit BIT of each division.
`default_nettype none

module r2h_cell #(
  parameter int BIT = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire r2h_pkg::stage_t  in_stage,
  output logic                  out_valid,
  output r2h_pkg::stage_t       out_stage
);

  logic [r2h_pkg::REM_W-1:0] sat_div, hue_div;
  r2h_pkg::stage_t           stage_next;

  always_comb begin
    sat_div    = {{(r2h_pkg::REM_W-r2h_pkg::CH_W){1'b0}}, in_stage.mx} << BIT;
    hue_div    = {{(r2h_pkg::REM_W-r2h_pkg::CH_W){1'b0}}, in_stage.delta} << BIT;
    stage_next = in_stage;
    if (in_stage.sat_rem >= sat_div) begin
      stage_next.sat_rem    = in_stage.sat_rem - sat_div;
      stage_next.sat_q[BIT] = 1'b1;
    end
    if (in_stage.hue_rem >= hue_div) begin
      stage_next.hue_rem    = in_stage.hue_rem - hue_div;
      stage_next.hue_q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/r2h_back.sv */
// r2h_back: adds the hue offset, wraps negatives and holds the output word.
// Depends on r2h_pkg and r2h_hsv_if.
`default_nettype none

module r2h_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire r2h_pkg::stage_t  in_stage,
  r2h_hsv_if.source             hsv
);

  logic [r2h_pkg::HSUM_W-1:0] base, q_ext, off, sum, hue_next;

  always_comb begin
    case (in_stage.sector)
      r2h_pkg::SEC_RED:   base = '0;
      r2h_pkg::SEC_GREEN: base = r2h_pkg::HUE_SECTOR << 1;
      r2h_pkg::SEC_BLUE:  base = r2h_pkg::HUE_SECTOR << 2;
      default:            base = '0;
    endcase
    q_ext = {{(r2h_pkg::HSUM_W-r2h_pkg::QBITS){1'b0}}, in_stage.hue_q};
    off   = in_stage.neg ? (-q_ext) : q_ext;
    sum   = base + off;
    // only the red sector can go negative
    hue_next = sum[r2h_pkg::HSUM_W-1] ? (sum + r2h_pkg::HUE_FULL) : sum;
    if (in_stage.grey) hue_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv.valid <= 1'b0;
    end else if (en) begin
      hsv.valid <= in_valid;
    end
    if (en) begin
      hsv.hue        <= hue_next[r2h_pkg::HUE_W-1:0];
      hsv.saturation <= in_stage.grey ? '0 : in_stage.sat_q[r2h_pkg::CH_W-1:0];
      hsv.brightness <= in_stage.mx;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_hsv_converter.sv */
// rgb_to_hsv_converter: top level; front stage, divider cell chain, output.
// Depends on r2h_pkg, r2h_if, r2h_front, r2h_cell, r2h_back.
//
// Usage:
//   pix  (sink)   : one RGB word per handshake, 8 bits per channel.
//   hsv  (source) : one word per pixel: hue in 1/16 degree (0..5759),
//                   saturation 0..255, brightness = largest channel.
//   A word moves on a rising edge with valid and ready both high.
// Path: from accept to hsv.valid through the front stage, ten division
//   cells that each settle one quotient bit, and the output register.
// Throughput: one pixel per cycle while the output is not stalled; the whole chain shifts in lockstep.
// Stall: when hsv.valid is high and hsv.ready low, every stage holds and
//   pix.ready drops; pix.ready is high whenever the output register is
//   empty or being taken.
// Reset: rst (synchronous) clears all stage valid bits; no word is in
//   flight afterwards. Pixels are independent; nothing else is stored.
`default_nettype none

module rgb_to_hsv_converter (
  input  wire logic   clk,
  input  wire logic   rst,
  r2h_rgb_if.sink     pix,
  r2h_hsv_if.source   hsv
);

  localparam int N = r2h_pkg::QBITS;

  logic              en;
  logic [N:0]        vld;
  r2h_pkg::stage_t   stg [N+1];

  assign en = !hsv.valid || hsv.ready;

  r2h_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .pix   (pix),
    .valid (vld[0]),
    .stage (stg[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    r2h_cell #(.BIT(N - 1 - i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[i]),
      .in_stage  (stg[i]),
      .out_valid (vld[i+1]),
      .out_stage (stg[i+1])
    );
  end

  r2h_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vld[N]),
    .in_stage (stg[N]),
    .hsv      (hsv)
  );

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv.valid |-> (hsv.hue < 13'd5760))
    else $error("hue out of range");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (hsv.valid && hsv.saturation == 8'd0) |-> (hsv.hue == 13'd0))
    else $error("hue nonzero with zero saturation");

  a_black_sat: assert property (@(posedge clk) disable iff (rst)
    (hsv.valid && hsv.brightness == 8'd0) |-> (hsv.saturation == 8'd0))
    else $error("saturation nonzero for black pixel");

  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("divider chain moved while stalled");

endmodule

`default_nettype wire

/* tb/rgb_to_hsv_converter_test.sv */
// rgb_to_hsv_converter_test: self-checking bench for the RGB to HSV converter.
// Drives corner pixels and then random ones, with idle gaps and a long output stall.
// Depends on r2h_pkg, r2h_if and the rgb_to_hsv_converter RTL.
`default_nettype none

module rgb_to_hsv_converter_test;

  localparam int SECTOR     = int'(r2h_pkg::HUE_SECTOR);
  localparam int FULL_TURN  = int'(r2h_pkg::HUE_FULL);
  localparam int RAND_ITEMS = 1000;
  localparam int IDLE_PCT   = 21;
  localparam int DRAIN_CYC  = 40;

  // {red, green, blue}
  localparam logic [23:0] CORNER_PIXELS [24] = '{
    24'h000000, 24'hffffff, 24'h808080, 24'h010101,   // black and greys
    24'hff0000, 24'h00ff00, 24'h0000ff,               // primaries
    24'hffff00, 24'h00ffff, 24'hff00ff,               // ties for largest
    24'hff000a, 24'hff0a00, 24'h0aff00, 24'h00ff0a,   // each sector, both signs
    24'h0a00ff, 24'h000aff, 24'h010000, 24'h000001,
    24'hfffefe, 24'hfffffe, 24'hfefeff, 24'hc86432,
    24'h7f80ff, 24'h55aa01
  };

  typedef struct {
    logic [r2h_pkg::HUE_W-1:0] hue;
    logic [r2h_pkg::CH_W-1:0]  sat;
    logic [r2h_pkg::CH_W-1:0]  val;
  } hsv_word_t;

  class hsv_scoreboard;
    hsv_word_t pending[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function hsv_word_t predict_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      hsv_word_t          w;
      r2h_pkg::sector_t   sec;
      int                 rv, gv, bv;
      int                 mx, mn, delta, sat, diff, hue;
      rv  = int'(r);
      gv  = int'(g);
      bv  = int'(b);
      mx  = rv;
      sec = r2h_pkg::SEC_RED;
      if (gv > mx) begin
        mx  = gv;
        sec = r2h_pkg::SEC_GREEN;
      end
      if (bv > mx) begin
        mx  = bv;
        sec = r2h_pkg::SEC_BLUE;
      end
      mn = rv;
      if (gv < mn) mn = gv;
      if (bv < mn) mn = bv;
      delta = mx - mn;
      sat   = (mx != 0) ? (delta * 255) / mx : 0;
      hue   = 0;
      if (sat != 0 && delta != 0) begin
        case (sec)
          r2h_pkg::SEC_RED:   diff = gv - bv;
          r2h_pkg::SEC_GREEN: diff = bv - rv;
          default:            diff = rv - gv;
        endcase
        // quotient truncates toward zero; only the red sector can go negative
        hue = 2 * SECTOR * int'(sec) + (diff * SECTOR) / delta;
        if (hue < 0) hue += FULL_TURN;
      end
      w.hue = hue[r2h_pkg::HUE_W-1:0];
      w.sat = sat[r2h_pkg::CH_W-1:0];
      w.val = mx[r2h_pkg::CH_W-1:0];
      return w;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pending.push_back(predict_hsv(r, g, b));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_hsv(logic [r2h_pkg::HUE_W-1:0] hue, logic [r2h_pkg::CH_W-1:0] sat,
                   logic [r2h_pkg::CH_W-1:0] val);
      hsv_word_t w;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("hsv word %0d/%0d/%0d with nothing pending",
                                  hue, sat, val));
      end else begin
        w = pending.pop_front();
        if (hue !== w.hue)
          report_mismatch($sformatf("hue %0d, want %0d", hue, w.hue));
        if (sat !== w.sat)
          report_mismatch($sformatf("saturation %0d, want %0d", sat, w.sat));
        if (val !== w.val)
          report_mismatch($sformatf("brightness %0d, want %0d", val, w.val));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic steady = 1'b0;   // no idling on either side while set
  int   hsv_taken = 0;

  hsv_scoreboard sb = new();

  r2h_rgb_if pix();
  r2h_hsv_if hsv();

  rgb_to_hsv_converter DUT (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .hsv (hsv)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk); while (!pix.ready);
    sb.note_pixel(r, g, b);
  endtask

  function automatic logic [23:0] random_pixel();
    logic [7:0] c [3];
    int         base, k;
    case ($urandom_range(3))
      0: for (k = 0; k < 3; k++) c[k] = 8'($urandom_range(255));
      1: begin
        // nearly grey: tiny delta, tests the divider at low precision
        base = $urandom_range(252);
        for (k = 0; k < 3; k++) c[k] = 8'(base + $urandom_range(3));
      end
      2: begin
        // two channels tie, third random
        c[0] = 8'($urandom_range(255));
        c[1] = c[0];
        c[2] = 8'($urandom_range(255));
        k = $urandom_range(2);
        if (k != 2) begin
          base = int'(c[k]);
          c[k] = c[2];
          c[2] = 8'(base);
        end
      end
      default:
        for (k = 0; k < 3; k++)
          case ($urandom_range(2))
            0: c[k] = 8'h00;
            1: c[k] = 8'hff;
            default: c[k] = 8'($urandom_range(255));
          endcase
    endcase
    return {c[0], c[1], c[2]};
  endfunction

  // stimulus and end of run
  initial begin
    logic [23:0] p;
    int          i;
    rst       <= 1'b1;
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (CORNER_PIXELS[j])
      send_pixel(CORNER_PIXELS[j][23:16], CORNER_PIXELS[j][15:8], CORNER_PIXELS[j][7:0]);
    for (i = 0; i < RAND_ITEMS; i++) begin
      steady = (i >= 500 && i < 700);
      p = random_pixel();
      send_pixel(p[23:16], p[15:8], p[7:0]);
    end
    steady = 1'b0;
    pix.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d hsv words never arrived", sb.pending.size()));
    if (sb.errors == 0)
      $display("[rgb_to_hsv_converter] OK");
    else
      $display("[rgb_to_hsv_converter] ERROR");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    hsv.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hsv.valid && hsv.ready) begin
        sb.check_hsv(hsv.hue, hsv.saturation, hsv.brightness);
        hsv_taken++;
      end
      if (!held && hsv_taken == 300) begin
        held      = 1'b1;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        hsv.ready <= 1'b0;
      end else if (steady) begin
        hsv.ready <= 1'b1;
      end else begin
        hsv.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #4000000;
    $display("[rgb_to_hsv_converter] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/r2h_pkg.sv
hw/rtl/r2h_if.sv
hw/rtl/r2h_front.sv
hw/rtl/r2h_cell.sv
hw/rtl/r2h_back.sv
hw/rtl/rgb_to_hsv_converter.sv
tb/rgb_to_hsv_converter_test.sv
